// ===== rtl/tsa_pkg.sv =====
// shared types, widths and constants of the triangle solid angle pipeline
package tsa_pkg;

  localparam int COORD_W   = 24;
  localparam int PROD_W    = 2 * COORD_W;
  localparam int CROSS_W   = 2 * COORD_W + 1;
  localparam int SQ_W      = 2 * COORD_W;
  localparam int LEN_W     = COORD_W;
  localparam int TRIPLE_W  = 3 * COORD_W + 1;
  localparam int DEN_W     = 3 * COORD_W + 3;
  localparam int MAG_W     = 3 * COORD_W + 2;
  localparam int NORM_BITS = 60;
  localparam int ALIGN_W   = (MAG_W > NORM_BITS) ? MAG_W : NORM_BITS;
  localparam int ALIGN_LVLS = $clog2(ALIGN_W);
  localparam int ROT_W     = NORM_BITS + 3;
  localparam int ANG_Z_W   = 32;
  localparam int ATAN_W    = 30;
  localparam int ATAN_ONE_POS = 29;
  localparam int OUT_W     = 31;
  localparam int ANGLE_ITERATIONS_DEF = 28;

  localparam logic [OUT_W-1:0] HALF_PI_CODE  = 31'd843314857;
  localparam logic [OUT_W-1:0] FULL_CODE_MAX = 31'd1686629713;

  typedef logic signed [COORD_W-1:0] coord_t;

  typedef struct packed {
    coord_t a_x;
    coord_t a_y;
    coord_t a_z;
    coord_t b_x;
    coord_t b_y;
    coord_t b_z;
    coord_t c_x;
    coord_t c_y;
    coord_t c_z;
  } tsa_in_t;

  typedef struct packed {
    logic [OUT_W-1:0] solid_angle;
    logic             degenerate;
  } tsa_out_t;

  typedef struct packed {
    logic signed [TRIPLE_W-1:0] triple;
    logic signed [CROSS_W-1:0]  ab;
    logic signed [CROSS_W-1:0]  ac;
    logic signed [CROSS_W-1:0]  bc;
  } side_t;

  typedef struct packed {
    side_t                 side;
    logic [2:0][SQ_W-1:0]  sq;
  } front_t;

  typedef struct packed {
    side_t                 side;
    logic [2:0][LEN_W-1:0] len;
  } len_t;

  typedef struct packed {
    logic [MAG_W-1:0] x;
    logic [MAG_W-1:0] y;
    logic             neg_den;
    logic             degenerate;
  } vec_t;

  function automatic logic signed [PROD_W-1:0] mul_cc(input coord_t x, input coord_t y);
    return PROD_W'(x) * PROD_W'(y);
  endfunction

  // atan(2^-i) in units of 2^-29 rad
  function automatic logic [ATAN_W-1:0] atan_step(input int unsigned idx);
    logic [ATAN_W-1:0] val;
    case (idx)
      0: val = 30'd421657428;
      1: val = 30'd248918915;
      2: val = 30'd131521918;
      3: val = 30'd66762579;
      4: val = 30'd33510843;
      5: val = 30'd16771758;
      6: val = 30'd8387925;
      7: val = 30'd4194219;
      8: val = 30'd2097141;
      9: val = 30'd1048575;
      default: begin
        if (idx <= ATAN_ONE_POS) val = ATAN_W'(1) << (ATAN_ONE_POS - idx);
        else val = '0;
      end
    endcase
    return val;
  endfunction

endpackage

// ===== rtl/tsa_front.sv =====
// input register, products, cross and dot products, squared lengths, triple product
module tsa_front
  import tsa_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    adv_i,
  input  logic    valid_i,
  input  tsa_in_t data_i,
  output logic    valid_o,
  output front_t  data_o
);

  localparam int STAGES = 6;
  localparam int PP_W   = 2 * COORD_W + 1;

  typedef struct packed {
    logic signed [CROSS_W-1:0] ab;
    logic signed [CROSS_W-1:0] ac;
    logic signed [CROSS_W-1:0] bc;
    logic [2:0][SQ_W-1:0]      sq;
  } carry_t;

  logic [STAGES-1:0] v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (adv_i) begin
      v_q <= {v_q[STAGES-2:0], valid_i};
    end
  end

  assign valid_o = v_q[STAGES-1];

  // stage 0: input register
  tsa_in_t in_q;
  coord_t  va [3];
  coord_t  vb [3];
  coord_t  vc [3];

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      in_q <= data_i;
    end
  end

  assign va[0] = in_q.a_x;
  assign va[1] = in_q.a_y;
  assign va[2] = in_q.a_z;
  assign vb[0] = in_q.b_x;
  assign vb[1] = in_q.b_y;
  assign vb[2] = in_q.b_z;
  assign vc[0] = in_q.c_x;
  assign vc[1] = in_q.c_y;
  assign vc[2] = in_q.c_z;

  // stage 1: all pairwise products
  logic signed [PROD_W-1:0] cp_q  [6];
  logic signed [PROD_W-1:0] dab_q [3];
  logic signed [PROD_W-1:0] dac_q [3];
  logic signed [PROD_W-1:0] dbc_q [3];
  logic signed [PROD_W-1:0] sqa_q [3];
  logic signed [PROD_W-1:0] sqb_q [3];
  logic signed [PROD_W-1:0] sqc_q [3];
  coord_t                   a1_q  [3];

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      cp_q[0] <= mul_cc(vb[1], vc[2]);
      cp_q[1] <= mul_cc(vb[2], vc[1]);
      cp_q[2] <= mul_cc(vb[2], vc[0]);
      cp_q[3] <= mul_cc(vb[0], vc[2]);
      cp_q[4] <= mul_cc(vb[0], vc[1]);
      cp_q[5] <= mul_cc(vb[1], vc[0]);
      for (int k = 0; k < 3; k++) begin
        dab_q[k] <= mul_cc(va[k], vb[k]);
        dac_q[k] <= mul_cc(va[k], vc[k]);
        dbc_q[k] <= mul_cc(vb[k], vc[k]);
        sqa_q[k] <= mul_cc(va[k], va[k]);
        sqb_q[k] <= mul_cc(vb[k], vb[k]);
        sqc_q[k] <= mul_cc(vc[k], vc[k]);
        a1_q[k]  <= va[k];
      end
    end
  end

  // stage 2: cross product, dot products, squared lengths
  logic signed [CROSS_W-1:0] cr_q [3];
  carry_t                    c2_q;
  coord_t                    a2_q [3];

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      cr_q[0] <= CROSS_W'(cp_q[0]) - CROSS_W'(cp_q[1]);
      cr_q[1] <= CROSS_W'(cp_q[2]) - CROSS_W'(cp_q[3]);
      cr_q[2] <= CROSS_W'(cp_q[4]) - CROSS_W'(cp_q[5]);
      c2_q.ab <= CROSS_W'(dab_q[0]) + CROSS_W'(dab_q[1]) + CROSS_W'(dab_q[2]);
      c2_q.ac <= CROSS_W'(dac_q[0]) + CROSS_W'(dac_q[1]) + CROSS_W'(dac_q[2]);
      c2_q.bc <= CROSS_W'(dbc_q[0]) + CROSS_W'(dbc_q[1]) + CROSS_W'(dbc_q[2]);
      c2_q.sq[0] <= SQ_W'($unsigned(sqa_q[0])) + SQ_W'($unsigned(sqa_q[1]))
                  + SQ_W'($unsigned(sqa_q[2]));
      c2_q.sq[1] <= SQ_W'($unsigned(sqb_q[0])) + SQ_W'($unsigned(sqb_q[1]))
                  + SQ_W'($unsigned(sqb_q[2]));
      c2_q.sq[2] <= SQ_W'($unsigned(sqc_q[0])) + SQ_W'($unsigned(sqc_q[1]))
                  + SQ_W'($unsigned(sqc_q[2]));
      for (int k = 0; k < 3; k++) begin
        a2_q[k] <= a1_q[k];
      end
    end
  end

  // stage 3: cross components split in two halves times a
  logic signed [PP_W-1:0] tlo_q [3];
  logic signed [PP_W-1:0] thi_q [3];
  carry_t                 c3_q;

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      for (int k = 0; k < 3; k++) begin
        tlo_q[k] <= PP_W'($signed({1'b0, cr_q[k][COORD_W-1:0]})) * PP_W'(a2_q[k]);
        thi_q[k] <= PP_W'($signed(cr_q[k][CROSS_W-1:COORD_W])) * PP_W'(a2_q[k]);
      end
      c3_q <= c2_q;
    end
  end

  // stage 4: recombine halves
  logic signed [TRIPLE_W-1:0] term_q [3];
  carry_t                     c4_q;

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      for (int k = 0; k < 3; k++) begin
        term_q[k] <= (TRIPLE_W'(thi_q[k]) <<< COORD_W) + TRIPLE_W'(tlo_q[k]);
      end
      c4_q <= c3_q;
    end
  end

  // stage 5: triple product
  front_t out_q;

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      out_q.side.triple <= term_q[0] + term_q[1] + term_q[2];
      out_q.side.ab     <= c4_q.ab;
      out_q.side.ac     <= c4_q.ac;
      out_q.side.bc     <= c4_q.bc;
      out_q.sq          <= c4_q.sq;
    end
  end

  assign data_o = out_q;

endmodule

// ===== rtl/tsa_sqrt.sv =====
// three rounded square roots, one root bit per stage
module tsa_sqrt
  import tsa_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   adv_i,
  input  logic   valid_i,
  input  front_t data_i,
  output logic   valid_o,
  output len_t   data_o
);

  localparam int STEPS = LEN_W;
  localparam int TRY_W = SQ_W + 2;

  typedef logic [2:0][SQ_W-1:0]  rem_t;
  typedef logic [2:0][LEN_W-1:0] root_t;

  logic [STEPS:0] v_q;
  rem_t           rem_q  [STEPS];
  root_t          root_q [STEPS];
  side_t          side_q [STEPS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (adv_i) begin
      v_q <= {v_q[STEPS-1:0], valid_i};
    end
  end

  assign valid_o = v_q[STEPS];

  for (genvar s = 0; s < STEPS; s++) begin : g_step
    localparam int K = STEPS - 1 - s;
    rem_t  rem_in;
    rem_t  rem_d;
    root_t root_in;
    root_t root_d;
    side_t side_in;

    if (s == 0) begin : g_first
      assign rem_in  = data_i.sq;
      assign root_in = '0;
      assign side_in = data_i.side;
    end else begin : g_next
      assign rem_in  = rem_q[s-1];
      assign root_in = root_q[s-1];
      assign side_in = side_q[s-1];
    end

    // try setting root bit K: needs (r<<(K+1)) + 4^K off the remainder
    always_comb begin
      logic [TRY_W-1:0] trial;
      rem_d  = rem_in;
      root_d = root_in;
      trial  = '0;
      for (int l = 0; l < 3; l++) begin
        trial = (TRY_W'(root_in[l]) << (K + 1)) + (TRY_W'(1) << (2 * K));
        if (TRY_W'(rem_in[l]) >= trial) begin
          rem_d[l]  = rem_in[l] - SQ_W'(trial);
          root_d[l] = root_in[l] | (LEN_W'(1) << K);
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        rem_q[s]  <= rem_d;
        root_q[s] <= root_d;
        side_q[s] <= side_in;
      end
    end
  end

  // round to nearest: bump when the remainder exceeds the root
  len_t out_q;

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      for (int l = 0; l < 3; l++) begin
        if (rem_q[STEPS-1][l] > SQ_W'(root_q[STEPS-1][l])) begin
          out_q.len[l] <= root_q[STEPS-1][l] + LEN_W'(1);
        end else begin
          out_q.len[l] <= root_q[STEPS-1][l];
        end
      end
      out_q.side <= side_q[STEPS-1];
    end
  end

  assign data_o = out_q;

endmodule

// ===== rtl/tsa_denom.sv =====
// denominator la*lb*lc + ab*lc + ac*lb + bc*la and atan2 operand selection
module tsa_denom
  import tsa_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic adv_i,
  input  logic valid_i,
  input  len_t data_i,
  output logic valid_o,
  output vec_t data_o
);

  localparam int STAGES = 5;
  localparam int LP_W   = 2 * LEN_W;
  localparam int PP_W   = 2 * LEN_W + 1;

  logic [STAGES-1:0] v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (adv_i) begin
      v_q <= {v_q[STAGES-2:0], valid_i};
    end
  end

  assign valid_o = v_q[STAGES-1];

  logic signed [CROSS_W-1:0] dot_in [3];
  logic [LEN_W-1:0]          len_in [3];

  // pairs: ab with lc, ac with lb, bc with la
  assign dot_in[0] = data_i.side.ab;
  assign dot_in[1] = data_i.side.ac;
  assign dot_in[2] = data_i.side.bc;
  assign len_in[0] = data_i.len[2];
  assign len_in[1] = data_i.len[1];
  assign len_in[2] = data_i.len[0];

  // stage 1
  logic [LP_W-1:0]            lab_q;
  logic [LP_W-1:0]            dlo_q [3];
  logic signed [PP_W-1:0]     dhi_q [3];
  logic [LEN_W-1:0]           lc1_q;
  logic signed [TRIPLE_W-1:0] tri1_q;

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      lab_q <= LP_W'(data_i.len[0]) * LP_W'(data_i.len[1]);
      for (int j = 0; j < 3; j++) begin
        dlo_q[j] <= LP_W'(dot_in[j][LEN_W-1:0]) * LP_W'(len_in[j]);
        dhi_q[j] <= PP_W'($signed(dot_in[j][CROSS_W-1:LEN_W]))
                  * PP_W'($signed({1'b0, len_in[j]}));
      end
      lc1_q  <= data_i.len[2];
      tri1_q <= data_i.side.triple;
    end
  end

  // stage 2
  logic signed [DEN_W-1:0]    dterm_q [3];
  logic [LP_W-1:0]            mlo_q;
  logic [LP_W-1:0]            mhi_q;
  logic signed [TRIPLE_W-1:0] tri2_q;

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      for (int j = 0; j < 3; j++) begin
        dterm_q[j] <= (DEN_W'(dhi_q[j]) <<< LEN_W) + DEN_W'(dlo_q[j]);
      end
      mlo_q  <= LP_W'(lab_q[LEN_W-1:0]) * LP_W'(lc1_q);
      mhi_q  <= LP_W'(lab_q[LP_W-1:LEN_W]) * LP_W'(lc1_q);
      tri2_q <= tri1_q;
    end
  end

  // stage 3
  logic [DEN_W-1:0]           labc_q;
  logic signed [DEN_W-1:0]    dsum_q;
  logic signed [TRIPLE_W-1:0] tri3_q;

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      labc_q <= (DEN_W'(mhi_q) << LEN_W) + DEN_W'(mlo_q);
      dsum_q <= dterm_q[0] + dterm_q[1] + dterm_q[2];
      tri3_q <= tri2_q;
    end
  end

  // stage 4
  logic signed [DEN_W-1:0] den_q;
  logic [MAG_W-1:0]        mag_q;
  logic [TRIPLE_W-1:0]     tri_abs;

  assign tri_abs = tri3_q[TRIPLE_W-1] ? $unsigned(-tri3_q) : $unsigned(tri3_q);

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      den_q <= $signed(labc_q) + dsum_q;
      mag_q <= MAG_W'(tri_abs);
    end
  end

  // stage 5: a negative denominator swaps the pair and sets neg_den, so tsa_angle adds a quarter turn
  vec_t                    out_q;
  logic signed [DEN_W-1:0] den_neg;

  assign den_neg = -den_q;

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      out_q.neg_den    <= den_q[DEN_W-1];
      out_q.degenerate <= (mag_q == '0) && (den_q == '0);
      if (den_q[DEN_W-1]) begin
        out_q.x <= mag_q;
        out_q.y <= MAG_W'(den_neg);
      end else begin
        out_q.x <= MAG_W'(den_q);
        out_q.y <= mag_q;
      end
    end
  end

  assign data_o = out_q;

endmodule

// ===== rtl/tsa_angle.sv =====
// staged normalizer and vectoring rotation pipeline for the atan2
module tsa_angle
  import tsa_pkg::*;
#(
  parameter int ITERS = ANGLE_ITERATIONS_DEF
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     adv_i,
  input  logic     valid_i,
  input  vec_t     data_i,
  output logic     valid_o,
  output tsa_out_t data_o
);

  localparam int LVLS   = ALIGN_LVLS;
  localparam int STAGES = LVLS + ITERS;
  localparam int TOT_W  = ANG_Z_W + 1;

  typedef struct packed {
    logic [ALIGN_W-1:0] x;
    logic [ALIGN_W-1:0] y;
    logic               neg_den;
    logic               degenerate;
  } al_t;

  typedef struct packed {
    logic signed [ROT_W-1:0]   x;
    logic signed [ROT_W-1:0]   y;
    logic signed [ANG_Z_W-1:0] z;
    logic                      neg_den;
    logic                      degenerate;
  } rot_t;

  logic [STAGES-1:0] v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (adv_i) begin
      v_q <= {v_q[STAGES-2:0], valid_i};
    end
  end

  assign valid_o = v_q[STAGES-1];

  // left-align the pair so the larger value's top bit lands at the msb
  al_t al_q [LVLS];

  for (genvar j = 0; j < LVLS; j++) begin : g_align
    localparam int SH = 1 << (LVLS - 1 - j);
    al_t al_in;
    al_t al_d;

    if (j == 0) begin : g_first
      assign al_in.x          = ALIGN_W'(data_i.x);
      assign al_in.y          = ALIGN_W'(data_i.y);
      assign al_in.neg_den    = data_i.neg_den;
      assign al_in.degenerate = data_i.degenerate;
    end else begin : g_next
      assign al_in = al_q[j-1];
    end

    always_comb begin
      logic [ALIGN_W-1:0] both;
      both = al_in.x | al_in.y;
      al_d = al_in;
      if (both[ALIGN_W-1 -: SH] == '0) begin
        al_d.x = al_in.x << SH;
        al_d.y = al_in.y << SH;
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        al_q[j] <= al_d;
      end
    end
  end

  rot_t rot_q [ITERS];

  for (genvar i = 0; i < ITERS; i++) begin : g_rot
    rot_t rin;
    rot_t rd;

    if (i == 0) begin : g_first
      assign rin.x          = ROT_W'(al_q[LVLS-1].x[ALIGN_W-1 -: NORM_BITS]);
      assign rin.y          = ROT_W'(al_q[LVLS-1].y[ALIGN_W-1 -: NORM_BITS]);
      assign rin.z          = '0;
      assign rin.neg_den    = al_q[LVLS-1].neg_den;
      assign rin.degenerate = al_q[LVLS-1].degenerate;
    end else begin : g_next
      assign rin = rot_q[i-1];
    end

    always_comb begin
      logic signed [ROT_W-1:0] xs;
      logic signed [ROT_W-1:0] ys;
      xs = rin.x;
      ys = rin.y;
      rd = rin;
      if (!ys[ROT_W-1] && (ys != '0)) begin
        rd.x = xs + (ys >>> i);
        rd.y = ys - (xs >>> i);
        rd.z = rin.z + ANG_Z_W'(atan_step(i));
      end else begin
        rd.x = xs - (ys >>> i);
        rd.y = ys + (xs >>> i);
        rd.z = rin.z - ANG_Z_W'(atan_step(i));
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        rot_q[i] <= rd;
      end
    end
  end

  // half angle units equal full angle in Q4.28, so no doubling is needed
  logic [TOT_W-1:0] total;

  assign total = {rot_q[ITERS-1].z[ANG_Z_W-1], rot_q[ITERS-1].z}
               + (rot_q[ITERS-1].neg_den ? TOT_W'(HALF_PI_CODE) : TOT_W'(0));

  always_comb begin
    data_o.degenerate = rot_q[ITERS-1].degenerate;
    if (rot_q[ITERS-1].degenerate || total[TOT_W-1]) begin
      data_o.solid_angle = '0;
    end else if (total > TOT_W'(FULL_CODE_MAX)) begin
      data_o.solid_angle = FULL_CODE_MAX;
    end else begin
      data_o.solid_angle = OUT_W'(total);
    end
  end

`ifndef SYNTHESIS
  a_align_msb: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[LVLS-1] && !al_q[LVLS-1].degenerate |->
      (al_q[LVLS-1].x[ALIGN_W-1] || al_q[LVLS-1].y[ALIGN_W-1]))
    else $error("normalizer left the pair unaligned");
`endif

endmodule

// ===== rtl/triangle_solid_angle.sv =====
// Throughput: one triangle per cycle; every stage is a register and the whole pipeline
// advances together whenever the output register is empty or being taken.
// Depth is set by the 24-step root extraction, the 7-level normalizer and the rotation stages.
// Reset: rst_ni clears all valid bits asynchronously; no result is pending after reset.
// top level: solid angle of a triangle seen from the origin
module triangle_solid_angle
  import tsa_pkg::*;
#(
  parameter int ANGLE_ITERATIONS = ANGLE_ITERATIONS_DEF
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  tsa_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output tsa_out_t out_data_o
);

  logic     adv;
  logic     front_valid;
  front_t   front_data;
  logic     len_valid;
  len_t     len_data;
  logic     vec_valid;
  vec_t     vec_data;
  logic     ang_valid;
  tsa_out_t ang_data;
  logic     out_valid_q;
  tsa_out_t out_q;

  // the pipeline moves whenever the output slot is free or being emptied
  assign adv        = !out_valid_q || !out_stall_i;
  assign in_stall_o = !adv;

  tsa_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .valid_i (in_valid_i),
    .data_i  (in_data_i),
    .valid_o (front_valid),
    .data_o  (front_data)
  );

  tsa_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .valid_i (front_valid),
    .data_i  (front_data),
    .valid_o (len_valid),
    .data_o  (len_data)
  );

  tsa_denom u_denom (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .valid_i (len_valid),
    .data_i  (len_data),
    .valid_o (vec_valid),
    .data_o  (vec_data)
  );

  tsa_angle #(
    .ITERS (ANGLE_ITERATIONS)
  ) u_angle (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .valid_i (vec_valid),
    .data_i  (vec_data),
    .valid_o (ang_valid),
    .data_o  (ang_data)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= ang_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q <= ang_data;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef SYNTHESIS
  a_degen_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.degenerate |-> out_data_o.solid_angle == '0)
    else $error("degenerate transaction with nonzero angle");

  a_angle_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.solid_angle <= FULL_CODE_MAX)
    else $error("solid angle above full range");

  a_ready_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("input stalled while output register is empty");
`endif

endmodule

// ===== dv/tb_triangle_solid_angle.sv =====
// self-checking testbench for the triangle solid angle pipeline
module tb_triangle_solid_angle;
  import tsa_pkg::*;

  typedef logic signed [127:0] wide_t;

  localparam int LATENCY = 44 + ANGLE_ITERATIONS_DEF;
  localparam int CYCLE_LIMIT = 600000;

  logic     clk_i;
  logic     rst_ni;
  logic     in_valid_i;
  logic     in_stall_o;
  tsa_in_t  in_data_i;
  logic     out_valid_o;
  logic     out_stall_i;
  tsa_out_t out_data_o;

  tsa_in_t  tri_pending[$];
  tsa_out_t angle_expected[$];
  int       fail_cnt = 0;
  int       cycle_cnt = 0;
  int       accepted_cnt = 0;
  int       send_gap;
  int       recv_gap;
  int       hold_cnt;
  bit       hold_done;
  bit       took_in = 1'b0;

  triangle_solid_angle dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_stall_o(in_stall_o), .in_data_i(in_data_i),
    .out_valid_o(out_valid_o), .out_stall_i(out_stall_i), .out_data_o(out_data_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic longint arctan_code(int i);
    longint tab[10] = '{421657428, 248918915, 131521918, 66762579, 33510843,
                        16771758, 8387925, 4194219, 2097141, 1048575};
    if (i < 10) return tab[i];
    if (i <= 29) return longint'(1) << (29 - i);
    return 0;
  endfunction

  // square root rounded to nearest
  function automatic longint unsigned root_round(longint unsigned n);
    longint unsigned r;
    r = 0;
    for (int b = 25; b >= 0; b--) begin
      if (((r | (64'd1 << b)) * (r | (64'd1 << b))) <= n) r = r | (64'd1 << b);
    end
    if (n - r * r > r) r = r + 1;
    return r;
  endfunction

  function automatic wide_t length_of(wide_t x, wide_t y, wide_t z);
    wide_t s;
    s = x * x + y * y + z * z;
    return wide_t'(root_round(s[63:0]));
  endfunction

  function automatic tsa_out_t solid_angle_of(tsa_in_t t);
    wide_t ax, ay, az, bx, by, bz, cx, cy, cz;
    wide_t trip, den, la, lb, lc;
    logic [127:0] ux, uy;
    longint rx, ry, xo, z, base, total;
    int m;
    tsa_out_t r;
    ax = wide_t'(t.a_x); ay = wide_t'(t.a_y); az = wide_t'(t.a_z);
    bx = wide_t'(t.b_x); by = wide_t'(t.b_y); bz = wide_t'(t.b_z);
    cx = wide_t'(t.c_x); cy = wide_t'(t.c_y); cz = wide_t'(t.c_z);
    trip = ax * (by * cz - bz * cy) + ay * (bz * cx - bx * cz) + az * (bx * cy - by * cx);
    if (trip < 0) trip = -trip;
    la = length_of(ax, ay, az);
    lb = length_of(bx, by, bz);
    lc = length_of(cx, cy, cz);
    den = la * lb * lc + (ax * bx + ay * by + az * bz) * lc
        + (ax * cx + ay * cy + az * cz) * lb + (bx * cx + by * cy + bz * cz) * la;
    r = '0;
    if (trip == 0 && den == 0) begin
      r.degenerate = 1'b1;
      return r;
    end
    base = 0;
    if (den >= 0) begin
      ux = den; uy = trip;
    end else begin
      ux = trip; uy = -den; base = 843314857;
    end
    m = 0;
    for (int k = 0; k < 128; k++) if (ux[k] || uy[k]) m = k + 1;
    if (m > NORM_BITS) begin
      ux = ux >> (m - NORM_BITS); uy = uy >> (m - NORM_BITS);
    end else begin
      ux = ux << (NORM_BITS - m); uy = uy << (NORM_BITS - m);
    end
    rx = ux[63:0];
    ry = uy[63:0];
    z = 0;
    for (int i = 0; i < ANGLE_ITERATIONS_DEF; i++) begin
      xo = rx;
      if (ry > 0) begin
        rx = rx + (ry >>> i); ry = ry - (xo >>> i); z = z + arctan_code(i);
      end else begin
        rx = rx - (ry >>> i); ry = ry + (xo >>> i); z = z - arctan_code(i);
      end
    end
    total = base + z;
    if (total < 0) total = 0;
    if (total > 1686629713) total = 1686629713;
    r.solid_angle = total[30:0];
    return r;
  endfunction

  function automatic int pick_gap();
    int p;
    p = $urandom_range(0, 99);
    if (p < 70) return 0;
    if (p < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic coord_t rand_coord(int kind);
    case (kind)
      0: return coord_t'($urandom);
      1: return coord_t'($urandom_range(0, 511)) - 256;
      2: return coord_t'($urandom_range(0, 131071)) - 65536;
      default: return ($urandom_range(0, 3) == 0) ? coord_t'(0) : coord_t'($urandom);
    endcase
  endfunction

  function automatic tsa_in_t rand_triangle();
    tsa_in_t t;
    int kind;
    kind = $urandom_range(0, 9);
    t.a_x = rand_coord(kind % 4); t.a_y = rand_coord(kind % 4); t.a_z = rand_coord(kind % 4);
    t.b_x = rand_coord(kind % 4); t.b_y = rand_coord(kind % 4); t.b_z = rand_coord(kind % 4);
    t.c_x = rand_coord(kind % 4); t.c_y = rand_coord(kind % 4); t.c_z = rand_coord(kind % 4);
    // collinear or zero corners give a flat or degenerate triangle
    if (kind == 8) begin
      t.c_x = t.b_x; t.c_y = t.b_y; t.c_z = t.b_z;
    end else if (kind == 9) begin
      t.a_x = '0; t.a_y = '0; t.a_z = '0;
    end
    return t;
  endfunction

  function automatic tsa_in_t make_tri(int ax, int ay, int az, int bx, int by, int bz,
                                       int cx, int cy, int cz);
    tsa_in_t t;
    t.a_x = coord_t'(ax); t.a_y = coord_t'(ay); t.a_z = coord_t'(az);
    t.b_x = coord_t'(bx); t.b_y = coord_t'(by); t.b_z = coord_t'(bz);
    t.c_x = coord_t'(cx); t.c_y = coord_t'(cy); t.c_z = coord_t'(cz);
    return t;
  endfunction

  // sender
  always @(negedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_data_i  <= '0;
      send_gap   = 0;
    end else if (!in_valid_i || took_in) begin
      if (send_gap > 0) begin
        send_gap = send_gap - 1;
        in_valid_i <= 1'b0;
      end else if (tri_pending.size() > 0) begin
        in_data_i  <= tri_pending.pop_front();
        in_valid_i <= 1'b1;
        send_gap = pick_gap();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // receiver, with one long hold-off to fill the pipeline
  always @(negedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      recv_gap  = 0;
      hold_cnt  = 0;
      hold_done = 1'b0;
    end else if (hold_cnt > 0) begin
      hold_cnt = hold_cnt - 1;
      out_stall_i <= 1'b1;
    end else if (!hold_done && accepted_cnt > 300) begin
      hold_done = 1'b1;
      hold_cnt  = 250;
      out_stall_i <= 1'b1;
    end else if (recv_gap > 0) begin
      recv_gap = recv_gap - 1;
      out_stall_i <= 1'b1;
    end else begin
      recv_gap = pick_gap();
      out_stall_i <= 1'b0;
    end
  end

  // monitor
  always @(posedge clk_i) begin
    tsa_out_t want;
    took_in = 1'b0;
    cycle_cnt = cycle_cnt + 1;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        took_in = 1'b1;
        accepted_cnt = accepted_cnt + 1;
        angle_expected.push_back(solid_angle_of(in_data_i));
      end
      if (out_valid_o && !out_stall_i) begin
        if (angle_expected.size() == 0) begin
          $display("%0t: unexpected transaction %h", $time, out_data_o);
          fail_cnt = fail_cnt + 1;
        end else begin
          want = angle_expected.pop_front();
          if (want.solid_angle !== out_data_o.solid_angle) begin
            $display("%0t: solid_angle expected %0d actual %0d", $time,
                     want.solid_angle, out_data_o.solid_angle);
            fail_cnt = fail_cnt + 1;
          end
          if (want.degenerate !== out_data_o.degenerate) begin
            $display("%0t: degenerate expected %0b actual %0b", $time,
                     want.degenerate, out_data_o.degenerate);
            fail_cnt = fail_cnt + 1;
          end
        end
      end
    end
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("triangle_solid_angle test failed");
      $finish;
    end
  end

  initial begin
    int q;
    rst_ni = 1'b0;
    q = 1 << 16;
    tri_pending.push_back(make_tri(0, 0, 0, 0, 0, 0, 0, 0, 0));
    tri_pending.push_back(make_tri(q, 0, 0, 0, q, 0, 0, 0, q));
    tri_pending.push_back(make_tri(q, 0, 0, 0, 0, q, 0, q, 0));
    tri_pending.push_back(make_tri(8388607, 8388607, 8388607, 8388607, 8388607,
                                   8388607, 8388607, 8388607, 8388607));
    tri_pending.push_back(make_tri(-8388608, -8388608, -8388608, -8388608, -8388608,
                                   -8388608, -8388608, -8388608, -8388608));
    tri_pending.push_back(make_tri(8388607, 0, 0, 0, -8388608, 0, 0, 0, 8388607));
    tri_pending.push_back(make_tri(-8388608, 0, 0, 0, 8388607, 0, 0, 0, -8388608));
    tri_pending.push_back(make_tri(q, 0, 0, -q, 0, 0, 0, q, 0));
    tri_pending.push_back(make_tri(q, 0, 0, -q / 2, 56756, 0, -q / 2, -56756, 0));
    tri_pending.push_back(make_tri(q, 0, 1, -q / 2, 56756, 1, -q / 2, -56756, 1));
    tri_pending.push_back(make_tri(q, 0, -1, -q / 2, 56756, -1, -q / 2, -56756, -1));
    tri_pending.push_back(make_tri(q, 0, 0, q, 0, 0, q, 0, 0));
    tri_pending.push_back(make_tri(q, 0, 0, 2 * q, 0, 0, -q, 0, 0));
    tri_pending.push_back(make_tri(0, 0, 0, q, 0, 0, 0, q, 0));
    tri_pending.push_back(make_tri(1, 0, 0, 0, 1, 0, 0, 0, 1));
    tri_pending.push_back(make_tri(-1, -1, -1, 1, -1, 0, 0, 1, -1));
    tri_pending.push_back(make_tri(q, q, q, -q, q, q, 0, -q, q));
    tri_pending.push_back(make_tri(8388607, -8388608, 1, -1, 8388607, -8388608,
                                   -8388608, 1, 8388607));
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    // sender pauses here until the directed transactions have all come back
    wait (tri_pending.size() == 0 && !in_valid_i && angle_expected.size() == 0);
    for (int n = 0; n < 1700; n++) tri_pending.push_back(rand_triangle());
    wait (tri_pending.size() == 0 && !in_valid_i && angle_expected.size() == 0);
    repeat (LATENCY + 20) @(posedge clk_i);
    if (fail_cnt == 0) begin
      $display("triangle_solid_angle test passed");
    end else begin
      $display("triangle_solid_angle test failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/tsa_pkg.sv
rtl/tsa_front.sv
rtl/tsa_sqrt.sv
rtl/tsa_denom.sv
rtl/tsa_angle.sv
rtl/triangle_solid_angle.sv
dv/tb_triangle_solid_angle.sv
